>>> rtl/core/fcab_pkg.sv
// ----------------------------------------------------------------------------
// fcab_pkg
// shared widths, register indexes, sequencer states and lane structs for the
// foot contact ankle balancer
// ----------------------------------------------------------------------------
`default_nettype none

package fcab_pkg;

  localparam int unsigned RAW_W   = 10;
  localparam int unsigned SCALE_W = 17;
  localparam int unsigned LEVEL_W = 11;
  localparam int unsigned DIFF_W  = 12;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned LIMIT_W = 24;
  localparam int unsigned ANGLE_W = 25;
  localparam int unsigned PROD_W  = 28;
  localparam int unsigned SUM_W   = 29;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned NLANES  = 4;

  localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN      = 3'd1;
  localparam logic [IDX_W-1:0] REG_DIFF_LIM  = 3'd2;
  localparam logic [IDX_W-1:0] REG_ANGLE_LIM = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCALE_A   = 3'd4;
  localparam logic [IDX_W-1:0] REG_SCALE_B   = 3'd5;
  localparam logic [IDX_W-1:0] REG_SCALE_C   = 3'd6;
  localparam logic [IDX_W-1:0] REG_SCALE_D   = 3'd7;

  localparam logic [LEVEL_W-1:0] RST_THRESHOLD = 11'd90;
  localparam logic [GAIN_W-1:0]  RST_GAIN      = 16'd1510;
  localparam logic [LEVEL_W-1:0] RST_DIFF_LIM  = 11'd100;
  localparam logic [LIMIT_W-1:0] RST_ANGLE_LIM = 24'd15099494;
  localparam logic [SCALE_W-1:0] RST_SCALE_A   = 17'd62415;
  localparam logic [SCALE_W-1:0] RST_SCALE_B   = 17'd66198;
  localparam logic [SCALE_W-1:0] RST_SCALE_C   = 17'd56497;
  localparam logic [SCALE_W-1:0] RST_SCALE_D   = 17'd56497;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MERGE,
    ST_MULT,
    ST_ACC,
    ST_OUT
  } fcab_state_t;

  typedef struct packed {
    logic scale_en;
    logic merge_en;
    logic mult_en;
    logic acc_en;
  } fcab_ctrl_t;

  typedef struct packed {
    logic                     land;
    logic signed [DIFF_W-1:0] pitch_diff;
    logic                     pitch_ok;
    logic signed [DIFF_W-1:0] roll_diff;
    logic                     roll_ok;
  } fcab_merge_t;

  function automatic logic [LEVEL_W-1:0] fcab_mag(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] n;
    n = v[DIFF_W-1] ? (~v + 1'b1) : v;
    return n[LEVEL_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/fcab_scale_lane.sv
// ----------------------------------------------------------------------------
// fcab_scale_lane
// one sensor lane: raw sample times its q16 factor, truncated, registered
// ----------------------------------------------------------------------------
`default_nettype none

module fcab_scale_lane (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [fcab_pkg::RAW_W-1:0]       raw,
  input  wire logic [fcab_pkg::SCALE_W-1:0]     factor,
  output logic      [fcab_pkg::LEVEL_W-1:0]     scaled
);

  localparam int unsigned P_W = fcab_pkg::RAW_W + fcab_pkg::SCALE_W;

  logic [P_W-1:0]                 prod;
  logic [fcab_pkg::LEVEL_W-1:0]   scaled_r;

  assign prod = {{fcab_pkg::SCALE_W{1'b0}}, raw} * {{fcab_pkg::RAW_W{1'b0}}, factor};

  always_ff @(posedge clk) begin
    if (en) begin
      scaled_r <= prod[P_W-1:16];
    end
  end

  assign scaled = scaled_r;

endmodule

`default_nettype wire

>>> rtl/core/fcab_diff_merge.sv
// ----------------------------------------------------------------------------
// fcab_diff_merge
// merges the four lanes: landing detect, pitch and roll difference choice
// and difference limit check, registered
// ----------------------------------------------------------------------------
`default_nettype none

module fcab_diff_merge (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [fcab_pkg::LEVEL_W-1:0]    lvl_a,
  input  wire logic [fcab_pkg::LEVEL_W-1:0]    lvl_b,
  input  wire logic [fcab_pkg::LEVEL_W-1:0]    lvl_c,
  input  wire logic [fcab_pkg::LEVEL_W-1:0]    lvl_d,
  input  wire logic [fcab_pkg::LEVEL_W-1:0]    threshold,
  input  wire logic [fcab_pkg::LEVEL_W-1:0]    diff_limit,
  output fcab_pkg::fcab_merge_t                merged
);

  logic signed [fcab_pkg::DIFF_W-1:0] sa, sb, sc, sd;
  logic signed [fcab_pkg::DIFF_W-1:0] a_b, d_c, c_b, d_a;
  logic signed [fcab_pkg::DIFF_W-1:0] pd, rd;
  fcab_pkg::fcab_merge_t              merged_r, merged_nxt;

  assign sa  = $signed({1'b0, lvl_a});
  assign sb  = $signed({1'b0, lvl_b});
  assign sc  = $signed({1'b0, lvl_c});
  assign sd  = $signed({1'b0, lvl_d});
  assign a_b = sa - sb;
  assign d_c = sd - sc;
  assign c_b = sc - sb;
  assign d_a = sd - sa;

  // |b-a| equals |a-b| and |c-d| equals |d-c|
  assign pd = (fcab_pkg::fcab_mag(a_b) >= fcab_pkg::fcab_mag(d_c)) ? a_b : d_c;
  assign rd = (fcab_pkg::fcab_mag(c_b) >= fcab_pkg::fcab_mag(d_a)) ? c_b : d_a;

  always_comb begin
    merged_nxt.land = (lvl_a >= threshold) && (lvl_b >= threshold) &&
                      (lvl_c >= threshold) && (lvl_d >= threshold);
    merged_nxt.pitch_diff = pd;
    merged_nxt.pitch_ok   = fcab_pkg::fcab_mag(pd) < diff_limit;
    merged_nxt.roll_diff  = rd;
    merged_nxt.roll_ok    = fcab_pkg::fcab_mag(rd) < diff_limit;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      merged_r <= merged_nxt;
    end
  end

  assign merged = merged_r;

endmodule

`default_nettype wire

>>> rtl/core/fcab_axis_lane.sv
// ----------------------------------------------------------------------------
// fcab_axis_lane
// one angle integrator: gain times difference, accumulate, symmetric clamp
// ----------------------------------------------------------------------------
`default_nettype none

module fcab_axis_lane (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire fcab_pkg::fcab_ctrl_t                  ctrl,
  input  wire logic [fcab_pkg::GAIN_W-1:0]           gain,
  input  wire logic [fcab_pkg::LIMIT_W-1:0]          angle_limit,
  input  wire logic signed [fcab_pkg::DIFF_W-1:0]    diff,
  input  wire logic                                  diff_ok,
  input  wire logic                                  update,
  output logic signed [fcab_pkg::ANGLE_W-1:0]        angle
);

  localparam int unsigned FULL_W = fcab_pkg::GAIN_W + 1 + fcab_pkg::DIFF_W;

  logic signed [FULL_W-1:0]              prod_full;
  logic signed [fcab_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic signed [fcab_pkg::SUM_W-1:0]     sum, lim_pos, lim_neg;
  logic signed [fcab_pkg::ANGLE_W-1:0]   acc_r, acc_nxt;

  assign prod_full = $signed({1'b0, gain}) * diff;
  assign prod_nxt  = diff_ok ? prod_full[fcab_pkg::PROD_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (ctrl.mult_en) begin
      prod_r <= prod_nxt;
    end
  end

  assign sum = {{(fcab_pkg::SUM_W - fcab_pkg::ANGLE_W){acc_r[fcab_pkg::ANGLE_W-1]}}, acc_r}
             + {{(fcab_pkg::SUM_W - fcab_pkg::PROD_W){prod_r[fcab_pkg::PROD_W-1]}}, prod_r};
  assign lim_pos = $signed({{(fcab_pkg::SUM_W - fcab_pkg::LIMIT_W){1'b0}}, angle_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (sum > lim_pos) begin
      acc_nxt = lim_pos[fcab_pkg::ANGLE_W-1:0];
    end else if (sum < lim_neg) begin
      acc_nxt = lim_neg[fcab_pkg::ANGLE_W-1:0];
    end else begin
      acc_nxt = sum[fcab_pkg::ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctrl.acc_en && update) begin
      acc_r <= acc_nxt;
    end
  end

  assign angle = acc_r;

endmodule

`default_nettype wire

>>> rtl/core/foot_contact_ankle_balancer.sv
// ----------------------------------------------------------------------------
// foot_contact_ankle_balancer
// four scaling lanes, a merge stage and two angle integrators that turn
// foot pressure samples into ankle pitch and roll commands
// ----------------------------------------------------------------------------
//  port group   dir  content
//  in_*         in   four raw pressure samples, one request per step
//  out_*        out  pitch, roll and landed flag, one request per step
//  cfg_*        in   register writes, index 0..7
//
//  each request steps through capture, lane multiply, merge, gain multiply,
//  accumulate and clamp, output load, in that order; one request in flight at a time
//  the output register stalls only the output load while a result waits
//  reset clears angles, landed flag and registers to their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module foot_contact_ankle_balancer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [39:0]                    in_tdata,   // sensor_a, sensor_b, sensor_c, sensor_d
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [55:0]                         out_tdata,  // pitch_angle, roll_angle, landed, zero pad
  input  wire logic                           cfg_we,
  input  wire logic [fcab_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [fcab_pkg::CFG_W-1:0]     cfg_data
);

  fcab_pkg::fcab_state_t                 state_r, state_nxt;
  fcab_pkg::fcab_ctrl_t                  ctrl;
  fcab_pkg::fcab_merge_t                 merged;

  logic [fcab_pkg::LEVEL_W-1:0]          threshold_r, diff_lim_r;
  logic [fcab_pkg::GAIN_W-1:0]           gain_r;
  logic [fcab_pkg::LIMIT_W-1:0]          angle_lim_r;
  logic [fcab_pkg::SCALE_W-1:0]          scale_r [fcab_pkg::NLANES];

  logic [fcab_pkg::RAW_W-1:0]            sample_r [fcab_pkg::NLANES];
  logic [fcab_pkg::LEVEL_W-1:0]          level [fcab_pkg::NLANES];

  logic                                  landed_r, landed_nxt;
  logic                                  update;
  logic signed [fcab_pkg::ANGLE_W-1:0]   pitch, roll;

  logic                                  out_valid_r, out_valid_nxt;
  logic [55:0]                           out_data_r;
  logic                                  in_acc, out_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= fcab_pkg::RST_THRESHOLD;
      gain_r      <= fcab_pkg::RST_GAIN;
      diff_lim_r  <= fcab_pkg::RST_DIFF_LIM;
      angle_lim_r <= fcab_pkg::RST_ANGLE_LIM;
      scale_r[0]  <= fcab_pkg::RST_SCALE_A;
      scale_r[1]  <= fcab_pkg::RST_SCALE_B;
      scale_r[2]  <= fcab_pkg::RST_SCALE_C;
      scale_r[3]  <= fcab_pkg::RST_SCALE_D;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcab_pkg::REG_THRESHOLD: threshold_r <= cfg_data[fcab_pkg::LEVEL_W-1:0];
        fcab_pkg::REG_GAIN:      gain_r      <= cfg_data[fcab_pkg::GAIN_W-1:0];
        fcab_pkg::REG_DIFF_LIM:  diff_lim_r  <= cfg_data[fcab_pkg::LEVEL_W-1:0];
        fcab_pkg::REG_ANGLE_LIM: angle_lim_r <= cfg_data[fcab_pkg::LIMIT_W-1:0];
        fcab_pkg::REG_SCALE_A:   scale_r[0]  <= cfg_data[fcab_pkg::SCALE_W-1:0];
        fcab_pkg::REG_SCALE_B:   scale_r[1]  <= cfg_data[fcab_pkg::SCALE_W-1:0];
        fcab_pkg::REG_SCALE_C:   scale_r[2]  <= cfg_data[fcab_pkg::SCALE_W-1:0];
        fcab_pkg::REG_SCALE_D:   scale_r[3]  <= cfg_data[fcab_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcab_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ctrl          = '0;
    in_tready     = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      fcab_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = fcab_pkg::ST_SCALE;
        end
      end
      fcab_pkg::ST_SCALE: begin
        ctrl.scale_en = 1'b1;
        state_nxt     = fcab_pkg::ST_MERGE;
      end
      fcab_pkg::ST_MERGE: begin
        ctrl.merge_en = 1'b1;
        state_nxt     = fcab_pkg::ST_MULT;
      end
      fcab_pkg::ST_MULT: begin
        ctrl.mult_en = 1'b1;
        state_nxt    = fcab_pkg::ST_ACC;
      end
      fcab_pkg::ST_ACC: begin
        ctrl.acc_en = 1'b1;
        state_nxt   = fcab_pkg::ST_OUT;
      end
      fcab_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = fcab_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fcab_pkg::ST_IDLE;
    endcase
  end

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < fcab_pkg::NLANES; i++) begin
        sample_r[i] <= in_tdata[i*fcab_pkg::RAW_W +: fcab_pkg::RAW_W];
      end
    end
  end

  // sensor lanes
  for (genvar g = 0; g < fcab_pkg::NLANES; g++) begin : g_lane
    fcab_scale_lane u_lane (
      .clk    (clk),
      .en     (ctrl.scale_en),
      .raw    (sample_r[g]),
      .factor (scale_r[g]),
      .scaled (level[g])
    );
  end

  fcab_diff_merge u_merge (
    .clk        (clk),
    .en         (ctrl.merge_en),
    .lvl_a      (level[0]),
    .lvl_b      (level[1]),
    .lvl_c      (level[2]),
    .lvl_d      (level[3]),
    .threshold  (threshold_r),
    .diff_limit (diff_lim_r),
    .merged     (merged)
  );

  // angles hold on the landing step and after it
  assign update     = !landed_r && !merged.land;
  assign landed_nxt = landed_r || (ctrl.acc_en && merged.land);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      landed_r <= 1'b0;
    end else begin
      landed_r <= landed_nxt;
    end
  end

  fcab_axis_lane u_pitch (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .gain        (gain_r),
    .angle_limit (angle_lim_r),
    .diff        (merged.pitch_diff),
    .diff_ok     (merged.pitch_ok),
    .update      (update),
    .angle       (pitch)
  );

  fcab_axis_lane u_roll (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .gain        (gain_r),
    .angle_limit (angle_lim_r),
    .diff        (merged.roll_diff),
    .diff_ok     (merged.roll_ok),
    .update      (update),
    .angle       (roll)
  );

  // output register
  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {5'b0, landed_r, roll, pitch};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> tb/sv/fcab_balance_check.sv
// ----------------------------------------------------------------------------
// fcab_balance_check
// watches the sample, command and register ports of the ankle balancer,
// keeps its own copy of the registers, angles and landed flag, predicts the
// command for every accepted sample request and compares each accepted
// command field by field against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcab_balance_check
  import fcab_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  input  wire logic                      in_tready,
  input  wire logic [NLANES*RAW_W-1:0]   in_tdata,   // sensor_a, sensor_b, sensor_c, sensor_d
  input  wire logic                      out_tvalid,
  input  wire logic                      out_tready,
  input  wire logic [55:0]               out_tdata,  // pitch_angle, roll_angle, landed, zero pad
  input  wire logic                      cfg_we,
  input  wire logic [IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data,
  output int unsigned                    mismatches,
  output int unsigned                    outstanding
);

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] roll;
    logic                      landed;
  } ankle_cmd_t;

  ankle_cmd_t         cmd_queue[$];
  logic [LEVEL_W-1:0] thr_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [LEVEL_W-1:0] dlim_q;
  logic [LIMIT_W-1:0] alim_q;
  logic [SCALE_W-1:0] scale_q[NLANES];
  longint             pitch_q;
  longint             roll_q;
  logic               landed_q;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // integrate one difference and clamp symmetrically
  function automatic longint integrate_angle(input longint acc, input longint diff);
    longint lim;
    lim = longint'(alim_q);
    if (magnitude(diff) < longint'(dlim_q)) acc = acc + longint'(gain_q) * diff;
    if (acc > lim) return lim;
    if (acc < -lim) return -lim;
    return acc;
  endfunction

  always @(posedge clk) begin
    longint     lvl[NLANES];
    longint     pd;
    longint     rd;
    ankle_cmd_t want;
    ankle_cmd_t got;
    int         k;
    if (!rst_n) begin
      thr_q      = RST_THRESHOLD;
      gain_q     = RST_GAIN;
      dlim_q     = RST_DIFF_LIM;
      alim_q     = RST_ANGLE_LIM;
      scale_q[0] = RST_SCALE_A;
      scale_q[1] = RST_SCALE_B;
      scale_q[2] = RST_SCALE_C;
      scale_q[3] = RST_SCALE_D;
      pitch_q    = 0;
      roll_q     = 0;
      landed_q   = 1'b0;
      cmd_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: thr_q      = cfg_data[LEVEL_W-1:0];
          REG_GAIN:      gain_q     = cfg_data[GAIN_W-1:0];
          REG_DIFF_LIM:  dlim_q     = cfg_data[LEVEL_W-1:0];
          REG_ANGLE_LIM: alim_q     = cfg_data[LIMIT_W-1:0];
          REG_SCALE_A:   scale_q[0] = cfg_data[SCALE_W-1:0];
          REG_SCALE_B:   scale_q[1] = cfg_data[SCALE_W-1:0];
          REG_SCALE_C:   scale_q[2] = cfg_data[SCALE_W-1:0];
          REG_SCALE_D:   scale_q[3] = cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end

      if (out_tvalid && out_tready) begin
        got.pitch  = out_tdata[ANGLE_W-1:0];
        got.roll   = out_tdata[2*ANGLE_W-1:ANGLE_W];
        got.landed = out_tdata[2*ANGLE_W];
        if (cmd_queue.size() == 0) begin
          $error("out: command with no request pending");
          mismatches++;
        end else begin
          want = cmd_queue.pop_front();
          if (got.pitch !== want.pitch) begin
            $error("pitch_angle: expected %0d, got %0d", want.pitch, got.pitch);
            mismatches++;
          end
          if (got.roll !== want.roll) begin
            $error("roll_angle: expected %0d, got %0d", want.roll, got.roll);
            mismatches++;
          end
          if (got.landed !== want.landed) begin
            $error("landed: expected %0d, got %0d", want.landed, got.landed);
            mismatches++;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        for (k = 0; k < NLANES; k++)
          lvl[k] = (longint'(in_tdata[k*RAW_W +: RAW_W]) * longint'(scale_q[k])) >> 16;
        if (!landed_q) begin
          if (lvl[0] >= longint'(thr_q) && lvl[1] >= longint'(thr_q) &&
              lvl[2] >= longint'(thr_q) && lvl[3] >= longint'(thr_q)) begin
            landed_q = 1'b1;
          end else begin
            pd = (magnitude(lvl[1] - lvl[0]) >= magnitude(lvl[2] - lvl[3])) ?
                 (lvl[0] - lvl[1]) : (lvl[3] - lvl[2]);
            rd = (magnitude(lvl[2] - lvl[1]) >= magnitude(lvl[3] - lvl[0])) ?
                 (lvl[2] - lvl[1]) : (lvl[3] - lvl[0]);
            pitch_q = integrate_angle(pitch_q, pd);
            roll_q  = integrate_angle(roll_q, rd);
          end
        end
        want.pitch  = pitch_q[ANGLE_W-1:0];
        want.roll   = roll_q[ANGLE_W-1:0];
        want.landed = landed_q;
        cmd_queue.insert(cmd_queue.size(), want);
      end
    end
    outstanding = cmd_queue.size();
  end

endmodule

>>> tb/sv/foot_contact_ankle_balancer_test.sv
// ----------------------------------------------------------------------------
// foot_contact_ankle_balancer_test
// drives foot pressure sample requests and register settings into the ankle
// balancer under random back-pressure, with directed corner cases first and
// the landing case last; a separate checker predicts and compares commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module foot_contact_ankle_balancer_test;
  import fcab_pkg::*;

  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 125;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic [NLANES*RAW_W-1:0] in_tdata   = '0;   // sensor_a, sensor_b, sensor_c, sensor_d
  logic                    out_tready = 1'b0;
  logic                    cfg_we     = 1'b0;
  logic [IDX_W-1:0]        cfg_index  = REG_THRESHOLD;
  logic [CFG_W-1:0]        cfg_data   = '0;
  wire logic               in_tready;
  wire logic               out_tvalid;
  wire logic [55:0]        out_tdata;         // pitch_angle, roll_angle, landed, zero pad

  int unsigned        mismatches;
  int unsigned        outstanding;
  int unsigned        idle_cycles = 0;
  bit                 steady      = 1'b0;
  bit                 hold_off    = 1'b0;
  logic [CFG_W-1:0]   reg_plan[8];
  logic [LEVEL_W-1:0] cur_threshold = RST_THRESHOLD;
  logic [SCALE_W-1:0] cur_scale[NLANES] = '{RST_SCALE_A, RST_SCALE_B, RST_SCALE_C, RST_SCALE_D};

  foot_contact_ankle_balancer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  fcab_balance_check i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned dice;
    dice = $urandom_range(0, 99);
    if (steady || dice < 70) return 0;
    if (dice < 96) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [NLANES*RAW_W-1:0] pack4(input int unsigned a, input int unsigned b,
                                                    input int unsigned c, input int unsigned d);
    return {d[RAW_W-1:0], c[RAW_W-1:0], b[RAW_W-1:0], a[RAW_W-1:0]};
  endfunction

  // command side back-pressure
  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
        out_tready <= 1'b1;
      end else begin
        stall = pick_gap();
        out_tready <= (stall == 0);
        if (stall > 1) repeat (stall - 1) @(negedge clk);
      end
    end
  end

  task automatic push_sample(input logic [NLANES*RAW_W-1:0] s);
    int unsigned gap;
    in_tdata  <= s;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic apply_plan();
    int k;
    for (k = REG_THRESHOLD; k <= REG_SCALE_D; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= k[IDX_W-1:0];
      cfg_data  <= reg_plan[k];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cur_threshold = reg_plan[REG_THRESHOLD][LEVEL_W-1:0];
    for (k = 0; k < NLANES; k++) cur_scale[k] = reg_plan[REG_SCALE_A + k][SCALE_W-1:0];
  endtask

  // kind 0: reset values, 1: random, otherwise a mix of zero, all ones and random values
  task automatic choose_plan(input int unsigned kind);
    int k;
    if (kind == 0) begin
      reg_plan[REG_THRESHOLD] = CFG_W'(RST_THRESHOLD);
      reg_plan[REG_GAIN]      = CFG_W'(RST_GAIN);
      reg_plan[REG_DIFF_LIM]  = CFG_W'(RST_DIFF_LIM);
      reg_plan[REG_ANGLE_LIM] = RST_ANGLE_LIM;
      reg_plan[REG_SCALE_A]   = CFG_W'(RST_SCALE_A);
      reg_plan[REG_SCALE_B]   = CFG_W'(RST_SCALE_B);
      reg_plan[REG_SCALE_C]   = CFG_W'(RST_SCALE_C);
      reg_plan[REG_SCALE_D]   = CFG_W'(RST_SCALE_D);
    end else begin
      for (k = REG_THRESHOLD; k <= REG_SCALE_D; k++) begin
        case ((kind == 1) ? 2 : $urandom_range(0, 2))
          0:       reg_plan[k] = '0;
          1:       reg_plan[k] = '1;
          default: reg_plan[k] = CFG_W'($urandom_range(0, 24'hFFFFFF));
        endcase
      end
    end
    // keep landing out of reach until the final phase
    if (reg_plan[REG_THRESHOLD][LEVEL_W-1:0] == '0) reg_plan[REG_THRESHOLD] = 24'd1;
  endtask

  task automatic send_block(input int unsigned count, input bit may_land);
    logic [NLANES*RAW_W-1:0] s;
    int                      base;
    int                      spread;
    int                      tilt;
    int                      v;
    int                      k;
    bit                      clustered;
    bit                      lands;
    tilt = int'($urandom_range(0, 80)) - 40;
    repeat (count) begin
      clustered = ($urandom_range(0, 9) < 7);
      base      = $urandom_range(0, 1023);
      spread    = $urandom_range(0, 120);
      for (k = 0; k < NLANES; k++) begin
        if (clustered) begin
          v = base + int'($urandom_range(0, 2 * spread)) - spread + ((k % 2 == 0) ? tilt : 0);
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
        end else begin
          v = $urandom_range(0, 1023);
        end
        s[k*RAW_W +: RAW_W] = v[RAW_W-1:0];
      end
      if (!may_land) begin
        lands = 1'b1;
        for (k = 0; k < NLANES; k++)
          if (((longint'(s[k*RAW_W +: RAW_W]) * longint'(cur_scale[k])) >> 16) <
              longint'(cur_threshold))
            lands = 1'b0;
        if (lands) s[$urandom_range(0, NLANES - 1)*RAW_W +: RAW_W] = '0;
      end
      push_sample(s);
    end
  endtask

  initial begin
    int unsigned phase;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset register values, nothing written yet
    push_sample(pack4(0, 0, 0, 0));
    push_sample(pack4(1023, 0, 0, 0));
    push_sample(pack4(0, 1023, 1023, 0));
    push_sample(pack4(40, 0, 0, 0));

    // unity scales: difference limit boundary and both selections
    settle();
    choose_plan(0);
    reg_plan[REG_SCALE_A] = 24'd65536;
    reg_plan[REG_SCALE_B] = 24'd65536;
    reg_plan[REG_SCALE_C] = 24'd65536;
    reg_plan[REG_SCALE_D] = 24'd65536;
    apply_plan();
    push_sample(pack4(99, 0, 0, 0));
    push_sample(pack4(100, 0, 0, 0));
    push_sample(pack4(0, 30, 30, 0));
    push_sample(pack4(0, 5, 50, 0));

    // small clamp, full gain
    settle();
    reg_plan[REG_GAIN]      = 24'hFFFF;
    reg_plan[REG_DIFF_LIM]  = 24'h7FF;
    reg_plan[REG_ANGLE_LIM] = 24'd200000;
    apply_plan();
    push_sample(pack4(50, 0, 0, 0));
    push_sample(pack4(0, 1023, 0, 0));
    push_sample(pack4(1023, 0, 0, 1023));

    // zero clamp
    settle();
    reg_plan[REG_ANGLE_LIM] = '0;
    apply_plan();
    push_sample(pack4(10, 0, 0, 0));

    // widest clamp
    settle();
    reg_plan[REG_ANGLE_LIM] = 24'hFFFFFF;
    apply_plan();
    push_sample(pack4(1023, 0, 0, 0));
    push_sample(pack4(0, 1023, 0, 0));
    push_sample(pack4(0, 0, 1023, 0));

    // zero difference limit, scale extremes
    settle();
    reg_plan[REG_DIFF_LIM] = '0;
    reg_plan[REG_SCALE_A]  = 24'h1FFFF;
    reg_plan[REG_SCALE_B]  = '0;
    apply_plan();
    push_sample(pack4(0, 0, 0, 0));
    push_sample(pack4(5, 0, 0, 0));
    push_sample(pack4(1023, 1023, 0, 0));

    // random phases, each with its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      choose_plan((phase == 0) ? 0 : $urandom_range(0, 2));
      apply_plan();
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        steady   = 1'b0;
        hold_off = 1'b1;
      end
      send_block(PHASE_ITEMS, 1'b0);
    end

    // landing last: the flag sticks until reset
    settle();
    steady = 1'b0;
    choose_plan(0);
    reg_plan[REG_THRESHOLD] = '0;
    apply_plan();
    push_sample(pack4(1023, 1023, 1023, 1023));
    send_block(20, 1'b1);

    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
